@@ hdl/ssi_pkg.sv @@
// Shared constants and types for the development rate pipeline.
// No dependencies; imported by the exponential lane and the top level.
package ssi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // kelvin offset 273.15 in Q8, rounded to 1/256
    localparam logic [16:0] KELVIN_OFFSET = 17'd69926;

    localparam int ARG_QW       = 30;
    localparam int SERIES_TERMS = 11;
    localparam int RCP_SHIFT    = 36;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    localparam logic [47:0] MAX48 = '1;
    localparam logic [31:0] MAX32 = '1;

    // argument set-up, argument divide, range split, series
    localparam int EXP_LAT = 3 + ARG_QW + 4 + 3 * SERIES_TERMS;

    typedef enum logic [2:0] {
        REG_OPT_TEMP,
        REG_RHO,
        REG_HA,
        REG_HL,
        REG_HH,
        REG_TL,
        REG_TH,
        REG_GAS
    } t_reg_idx;

    // exp(x) = m * 2^(k-30)
    typedef struct packed {
        logic [31:0]        m;
        logic signed [7:0]  k;
    } t_exp_res;

endpackage

@@ hdl/ssi_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Expects dividend < divisor * 2^QW. No package dependency.
module ssi_div #(
    parameter int QW = 30,
    parameter int DW = 47,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [QW+DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quo_in;
        logic [DW-1:0] w_den_in;
        logic [SW-1:0] w_side_in;
        logic [DW:0]   w_try;
        logic          w_ge;
        logic [DW:0]   w_diff;
        logic [DW-1:0] n_rem;

        if (j == 0) begin : g_first
            assign w_rem_in  = i_num[QW+DW-1:QW];
            assign w_low_in  = i_num[QW-1:0];
            assign w_quo_in  = '0;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_low_in  = r_low[j-1];
            assign w_quo_in  = r_quo[j-1];
            assign w_den_in  = r_den[j-1];
            assign w_side_in = r_side[j-1];
        end

        assign w_try  = {w_rem_in, w_low_in[QW-1]};
        assign w_ge   = w_try >= {1'b0, w_den_in};
        assign w_diff = w_try - {1'b0, w_den_in};
        assign n_rem  = w_ge ? w_diff[DW-1:0] : w_try[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_low[j]  <= {w_low_in[QW-2:0], 1'b0};
                r_quo[j]  <= {w_quo_in[QW-2:0], w_ge};
                r_den[j]  <= w_den_in;
                r_side[j] <= w_side_in;
            end
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

@@ hdl/ssi_exp.sv @@
// One exponential lane: exp(H/R*(1/t0-1/t)) as mantissa and power of two.
// Depends on ssi_pkg and ssi_div.
module ssi_exp import ssi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [16:0]        i_t,
    input  logic signed [20:0] i_h,
    input  logic [16:0]        i_t0,
    input  logic [12:0]        i_r,
    output t_exp_res           o_res
);

    // argument set-up
    logic signed [17:0] w_diff;
    logic [19:0] r_s1_hm;
    logic [16:0] r_s1_dm;
    logic        r_s1_neg;
    logic [29:0] r_s1_rt0;
    logic [16:0] r_s1_t;
    logic [36:0] w_hd;
    logic [54:0] r_s2_top;
    logic [46:0] r_s2_bot;
    logic        r_s2_neg;
    logic [78:0] w_topx;
    logic [76:0] r_s3_num;
    logic [46:0] r_s3_bot;
    logic        r_s3_neg;
    logic        r_s3_clamp;
    logic [ARG_QW-1:0] w_quo;
    logic [1:0]  w_side;

    assign w_diff = $signed({1'b0, i_t}) - $signed({1'b0, i_t0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_hm  <= i_h[20] ? 20'(-i_h) : i_h[19:0];
            r_s1_dm  <= w_diff[17] ? 17'(-w_diff) : w_diff[16:0];
            r_s1_neg <= i_h[20] ^ w_diff[17];
            r_s1_rt0 <= i_r * i_t0;
            r_s1_t   <= i_t;
        end
    end

    assign w_hd = r_s1_hm * r_s1_dm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_top <= {w_hd, 18'd0};
            r_s2_bot <= r_s1_rt0 * r_s1_t;
            r_s2_neg <= r_s1_neg;
        end
    end

    assign w_topx = {r_s2_top, 24'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_clamp <= r_s2_top >= {2'b00, r_s2_bot, 6'd0};
            r_s3_num   <= (r_s2_top >= {2'b00, r_s2_bot, 6'd0}) ? '0 : w_topx[76:0];
            r_s3_bot   <= r_s2_bot;
            r_s3_neg   <= r_s2_neg;
        end
    end

    ssi_div #(
        .QW (ARG_QW),
        .DW (47),
        .SW (2)
    ) u_arg_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_s3_num),
        .i_den  (r_s3_bot),
        .i_side ({r_s3_neg, r_s3_clamp}),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    // range split: y = x*log2(e), k = floor(y), z = frac(y)*ln2
    logic [30:0]        w_mag;
    logic [61:0]        r_m1_prod;
    logic               r_m1_neg;
    logic [61:0]        w_ysum;
    logic [30:0]        w_ym;
    logic [31:0]        w_upsum;
    logic [7:0]         w_up;
    logic [31:0]        w_fd;
    logic signed [7:0]  n_m2_k;
    logic [23:0]        n_m2_f;
    logic signed [7:0]  r_m2_k;
    logic [23:0]        r_m2_f;
    logic [53:0]        r_m3_zp;
    logic signed [7:0]  r_m3_k;
    logic [53:0]        w_zsum;
    logic [29:0]        r_m4_z;
    logic signed [7:0]  r_m4_k;

    assign w_mag = w_side[0] ? 31'h4000_0000 : {1'b0, w_quo};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_prod <= w_mag * LOG2E_Q30;
            r_m1_neg  <= w_side[1] && (w_mag != '0);
        end
    end

    assign w_ysum  = r_m1_prod + 62'h2000_0000;
    assign w_ym    = w_ysum[60:30];
    assign w_upsum = {1'b0, w_ym} + 32'h00FF_FFFF;
    assign w_up    = w_upsum[31:24];
    assign w_fd    = {w_up, 24'd0} - {1'b0, w_ym};

    always_comb begin
        if (r_m1_neg) begin
            n_m2_k = 8'(8'd0 - w_up);
            n_m2_f = w_fd[23:0];
        end else begin
            n_m2_k = {1'b0, w_ym[30:24]};
            n_m2_f = w_ym[23:0];
        end
    end

    assign w_zsum = r_m3_zp + 54'h80_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2_k  <= n_m2_k;
            r_m2_f  <= n_m2_f;
            r_m3_zp <= r_m2_f * LN2_Q30;
            r_m3_k  <= r_m2_k;
            r_m4_z  <= w_zsum[53:24];
            r_m4_k  <= r_m3_k;
        end
    end

    // Taylor series for 2^f, three stages per term
    logic [30:0]       r_a_p   [SERIES_TERMS];
    logic [29:0]       r_a_z   [SERIES_TERMS];
    logic [31:0]       r_a_sum [SERIES_TERMS];
    logic signed [7:0] r_a_k   [SERIES_TERMS];
    logic [67:0]       r_b_prod[SERIES_TERMS];
    logic [30:0]       r_b_p   [SERIES_TERMS];
    logic [29:0]       r_b_z   [SERIES_TERMS];
    logic [31:0]       r_b_sum [SERIES_TERMS];
    logic signed [7:0] r_b_k   [SERIES_TERMS];
    logic [30:0]       r_c_term[SERIES_TERMS];
    logic [29:0]       r_c_z   [SERIES_TERMS];
    logic [31:0]       r_c_sum [SERIES_TERMS];
    logic signed [7:0] r_c_k   [SERIES_TERMS];

    for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
        localparam int N = j + 1;
        localparam logic [36:0] RCP = 37'((64'd1 << RCP_SHIFT) / N);
        localparam logic [3:0]  NV  = 4'(N);

        logic [30:0]       w_term_in;
        logic [29:0]       w_z_in;
        logic [31:0]       w_sum_in;
        logic signed [7:0] w_k_in;
        logic [60:0]       w_tz;
        logic [30:0]       w_qe;
        logic [34:0]       w_qn;
        logic [34:0]       w_rem;
        logic [30:0]       n_term;

        if (j == 0) begin : g_first
            assign w_term_in = 31'h4000_0000;
            assign w_z_in    = r_m4_z;
            assign w_sum_in  = 32'h4000_0000;
            assign w_k_in    = r_m4_k;
        end else begin : g_next
            assign w_term_in = r_c_term[j-1];
            assign w_z_in    = r_c_z[j-1];
            assign w_sum_in  = r_c_sum[j-1];
            assign w_k_in    = r_c_k[j-1];
        end

        assign w_tz   = w_term_in * w_z_in;
        assign w_qe   = r_b_prod[j][66:36];
        assign w_qn   = w_qe * NV;
        assign w_rem  = {4'd0, r_b_p[j]} - w_qn;
        // reciprocal estimate is at most one low
        assign n_term = (w_rem >= 35'(NV)) ? w_qe + 31'd1 : w_qe;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_p[j]    <= w_tz[60:30];
                r_a_z[j]    <= w_z_in;
                r_a_sum[j]  <= w_sum_in;
                r_a_k[j]    <= w_k_in;
                r_b_prod[j] <= r_a_p[j] * RCP;
                r_b_p[j]    <= r_a_p[j];
                r_b_z[j]    <= r_a_z[j];
                r_b_sum[j]  <= r_a_sum[j];
                r_b_k[j]    <= r_a_k[j];
                r_c_term[j] <= n_term;
                r_c_z[j]    <= r_b_z[j];
                r_c_sum[j]  <= r_b_sum[j] + {1'b0, n_term};
                r_c_k[j]    <= r_b_k[j];
            end
        end
    end

    assign o_res.m = r_c_sum[SERIES_TERMS-1];
    assign o_res.k = r_c_k[SERIES_TERMS-1];

endmodule

@@ hdl/ssi_development_rate_top.sv @@
// Sharpe-Schoolfield-Ikemoto development rate: temperature in, rate out.
// Depends on ssi_pkg, ssi_exp and ssi_div.
//
// Usage:
//  Input channel: i_valid / o_stall carry one Celsius sample (Q7.8) per beat.
//  Output channel: o_valid / i_stall carry numerator, denominator, rate and
//  the overflow flag for each sample, in input order.
//  Model constants sit in eight registers on the APB port (byte address 4*i);
//  write them only while the pipeline is empty.
//  An accepted beat reaches the output through the 30-step argument dividers,
//  the 11-term exponential series, the 48-step numerator divider and the
//  32-step rate divider.
//  Throughput: one sample per cycle while o_stall is low.
//  When the receiver stalls, the output register holds its beat; the
//  pipeline keeps accepting until a result reaches its last stage, then
//  the whole pipeline freezes and o_stall rises. Nothing is lost.
//  Reset clears all valid bits and returns the registers to their defaults.
module ssi_development_rate_top import ssi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_temp_celsius,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [47:0]        o_rate_numerator,
    output logic [47:0]        o_rate_denominator,
    output logic [31:0]        o_development_rate,
    output logic               o_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NUM_QW  = 48;
    localparam int RATE_QW = 32;
    localparam int LAST    = EXP_LAT + 4 + NUM_QW + 1 + RATE_QW;
    localparam logic signed [7:0] NUM_BIAS = 8'(FRAC_BITS - 36);
    localparam logic signed [7:0] EXP_BIAS = 8'(FRAC_BITS - 30);
    localparam logic [47:0] DEN_ONE = 48'(1) << FRAC_BITS;

    // configuration registers
    logic [16:0]        r_opt_temp;
    logic [23:0]        r_rho;
    logic [17:0]        r_ha;
    logic signed [18:0] r_hl;
    logic [19:0]        r_hh;
    logic [16:0]        r_tl;
    logic [16:0]        r_th;
    logic [12:0]        r_gas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_temp <= 17'd3072;
            r_rho      <= 24'd786432;
            r_ha       <= 18'd12;
            r_hl       <= 19'sd12;
            r_hh       <= 20'd12;
            r_tl       <= 17'd3072;
            r_th       <= 17'd3072;
            r_gas      <= 13'd2035;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_OPT_TEMP: r_opt_temp <= pwdata[16:0];
                REG_RHO:      r_rho      <= pwdata[23:0];
                REG_HA:       r_ha       <= pwdata[17:0];
                REG_HL:       r_hl       <= pwdata[18:0];
                REG_HH:       r_hh       <= pwdata[19:0];
                REG_TL:       r_tl       <= pwdata[16:0];
                REG_TH:       r_th       <= pwdata[16:0];
                REG_GAS:      r_gas      <= pwdata[12:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_OPT_TEMP: prdata = {15'd0, r_opt_temp};
            REG_RHO:      prdata = {8'd0, r_rho};
            REG_HA:       prdata = {14'd0, r_ha};
            REG_HL:       prdata = {{13{r_hl[18]}}, r_hl};
            REG_HH:       prdata = {12'd0, r_hh};
            REG_TL:       prdata = {15'd0, r_tl};
            REG_TH:       prdata = {15'd0, r_th};
            REG_GAS:      prdata = {19'd0, r_gas};
        endcase
    end

    assign pready = 1'b1;

    // zero temperatures and gas constant read as one
    logic [16:0] w_tphi;
    logic [16:0] w_tl;
    logic [16:0] w_th;
    logic [12:0] w_gas;

    assign w_tphi = (r_opt_temp == '0) ? 17'd1 : r_opt_temp;
    assign w_tl   = (r_tl == '0) ? 17'd1 : r_tl;
    assign w_th   = (r_th == '0) ? 17'd1 : r_th;
    assign w_gas  = (r_gas == '0) ? 13'd1 : r_gas;

    // flow control: freeze only when a result would be dropped
    logic r_vld [LAST+1];
    logic r_out_valid;
    logic w_out_take;
    logic w_en;

    assign w_out_take = !r_out_valid || !i_stall;
    assign w_en       = w_out_take || !r_vld[LAST];
    assign o_stall    = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i <= LAST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // kelvin conversion
    logic signed [17:0] w_tk;
    logic [16:0]        r_t;
    logic [16:0]        r_td [EXP_LAT];

    assign w_tk = {{2{i_temp_celsius[15]}}, i_temp_celsius} + $signed({1'b0, KELVIN_OFFSET});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t      <= w_tk[16:0];
            r_td[0]  <= r_t;
            for (int i = 1; i < EXP_LAT; i++) begin
                r_td[i] <= r_td[i-1];
            end
        end
    end

    t_exp_res w_res_a;
    t_exp_res w_res_l;
    t_exp_res w_res_h;

    ssi_exp u_exp_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_t),
        .i_h   ({3'd0, r_ha}),
        .i_t0  (w_tphi),
        .i_r   (w_gas),
        .o_res (w_res_a)
    );

    ssi_exp u_exp_l (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_t),
        .i_h   ({{2{r_hl[18]}}, r_hl}),
        .i_t0  (w_tl),
        .i_r   (w_gas),
        .o_res (w_res_l)
    );

    ssi_exp u_exp_h (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_t),
        .i_h   ({1'b0, r_hh}),
        .i_t0  (w_th),
        .i_r   (w_gas),
        .o_res (w_res_h)
    );

    // floor(m * 2^e) saturated to 48 bits; top bit is the saturation flag
    function automatic logic [48:0] scale_exp(input logic [31:0] m,
                                              input logic signed [7:0] e);
        logic [48:0] v;
        logic [7:0]  s;
        v = '0;
        s = 8'(8'd0 - e);
        if (e >= 8'sd18) begin
            return {1'b1, MAX48};
        end else if (e >= 8'sd0) begin
            v = 49'(m) << e[4:0];
            return v[48] ? {1'b1, MAX48} : {1'b0, v[47:0]};
        end else if (s >= 8'd32) begin
            return '0;
        end else begin
            return {1'b0, 48'(m >> s[4:0])};
        end
    endfunction

    // P1: numerator factors, scaled exponentials
    logic [40:0]        r_p1_rt;
    logic [21:0]        r_p1_m20;
    logic signed [7:0]  r_p1_e;
    logic [48:0]        r_p1_t1;
    logic [48:0]        r_p1_t2;
    logic [32:0]        w_mr;

    assign w_mr = {1'b0, w_res_a.m} + 33'd512;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_rt  <= r_rho * r_td[EXP_LAT-1];
            r_p1_m20 <= w_mr[31:10];
            r_p1_e   <= w_res_a.k + NUM_BIAS;
            r_p1_t1  <= scale_exp(w_res_l.m, w_res_l.k + EXP_BIAS);
            r_p1_t2  <= scale_exp(w_res_h.m, w_res_h.k + EXP_BIAS);
        end
    end

    // P2: numerator product, first denominator sum
    logic [62:0]       r_p2_q;
    logic signed [7:0] r_p2_e;
    logic [47:0]       r_p2_den1;
    logic [47:0]       r_p2_t2;
    logic              r_p2_ov;
    logic [48:0]       w_d1;

    assign w_d1 = {1'b0, DEN_ONE} + {1'b0, r_p1_t1[47:0]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_q    <= r_p1_rt * r_p1_m20;
            r_p2_e    <= r_p1_e;
            r_p2_den1 <= w_d1[48] ? MAX48 : w_d1[47:0];
            r_p2_t2   <= r_p1_t2[47:0];
            r_p2_ov   <= r_p1_t1[48] | r_p1_t2[48] | w_d1[48];
        end
    end

    // P3: align numerator by its power of two, second denominator sum
    logic [91:0]  n_p3_qs;
    logic         n_p3_big;
    logic [7:0]   w_ns;
    logic [48:0]  w_d2;
    logic [91:0]  r_p3_qs;
    logic         r_p3_big;
    logic [47:0]  r_p3_den;
    logic         r_p3_ov;

    assign w_ns = 8'(8'd0 - r_p2_e);
    assign w_d2 = {1'b0, r_p2_den1} + {1'b0, r_p2_t2};

    always_comb begin
        n_p3_qs  = '0;
        n_p3_big = 1'b0;
        priority if (r_p2_q == '0) begin
            n_p3_qs = '0;
        end else if (r_p2_e >= 8'sd30) begin
            // quotient is at least 2^48 for any nonzero product
            n_p3_big = 1'b1;
        end else if (r_p2_e >= 8'sd0) begin
            n_p3_qs = 92'(r_p2_q) << r_p2_e[4:0];
        end else if (w_ns >= 8'd63) begin
            n_p3_qs = '0;
        end else begin
            n_p3_qs = 92'(r_p2_q >> w_ns[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_qs  <= n_p3_qs;
            r_p3_big <= n_p3_big;
            r_p3_den <= w_d2[48] ? MAX48 : w_d2[47:0];
            r_p3_ov  <= r_p2_ov | w_d2[48];
        end
    end

    // P4: numerator saturation test against the optimum temperature
    logic [64:0] r_p4_num;
    logic        r_p4_sat;
    logic [47:0] r_p4_den;
    logic        r_p4_ov;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_num <= r_p3_qs[64:0];
            r_p4_sat <= r_p3_big | (r_p3_qs[91:48] >= {27'd0, w_tphi});
            r_p4_den <= r_p3_den;
            r_p4_ov  <= r_p3_ov;
        end
    end

    logic [NUM_QW-1:0] w_nd_quo;
    logic [49:0]       w_nd_side;

    ssi_div #(
        .QW (NUM_QW),
        .DW (17),
        .SW (50)
    ) u_num_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_p4_num),
        .i_den  (w_tphi),
        .i_side ({r_p4_den, r_p4_ov, r_p4_sat}),
        .o_quo  (w_nd_quo),
        .o_side (w_nd_side)
    );

    // R1: numerator result, rate saturation test
    logic [47:0] w_num;
    logic [79:0] w_rnum;
    logic [47:0] r_r1_num;
    logic [47:0] r_r1_den;
    logic        r_r1_ov;
    logic        r_r1_rsat;

    assign w_num  = w_nd_side[0] ? MAX48 : w_nd_quo;
    assign w_rnum = 80'(w_num) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_num  <= w_num;
            r_r1_den  <= w_nd_side[49:2];
            r_r1_ov   <= w_nd_side[1] | w_nd_side[0];
            r_r1_rsat <= w_rnum[79:32] >= w_nd_side[49:2];
        end
    end

    logic [RATE_QW-1:0] w_rd_quo;
    logic [97:0]        w_rd_side;

    ssi_div #(
        .QW (RATE_QW),
        .DW (48),
        .SW (98)
    ) u_rate_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (80'(r_r1_num) << FRAC_BITS),
        .i_den  (r_r1_den),
        .i_side ({r_r1_num, r_r1_den, r_r1_ov, r_r1_rsat}),
        .o_quo  (w_rd_quo),
        .o_side (w_rd_side)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && r_vld[LAST]) begin
            o_rate_numerator   <= w_rd_side[97:50];
            o_rate_denominator <= w_rd_side[49:2];
            o_development_rate <= w_rd_side[0] ? MAX32 : w_rd_quo;
            o_overflow         <= w_rd_side[1] | w_rd_side[0];
        end
    end

    assign o_valid = r_out_valid;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld[LAST] && r_out_valid && i_stall))
        else $error("pipeline frozen without a blocked result");

    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rate_denominator >= DEN_ONE))
        else $error("denominator below one");

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for ssi_development_rate_top: drives Celsius samples,
// predicts numerator, denominator, rate and overflow in fixed point.
// Depends on ssi_pkg and the top level only.
`timescale 1ns / 1ps

module testbench import ssi_pkg::*; ();

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 156;
    localparam int N_RANDOM  = 700;
    localparam longint LIMIT = 400000;
    localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] M32 = 64'hFFFF_FFFF;

    typedef struct {
        logic [47:0] num;
        logic [47:0] den;
        logic [31:0] rate;
        logic        ovf;
    } t_rate_beat;

    typedef struct {
        logic signed [15:0] temp;
        bit                 typed;
        t_rate_beat         res;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_temp_celsius = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [47:0]        o_rate_numerator;
    logic [47:0]        o_rate_denominator;
    logic [31:0]        o_development_rate;
    logic               o_overflow;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    ssi_development_rate_top i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the model constants
    logic [16:0]        reg_tphi, reg_tl, reg_th;
    logic [23:0]        reg_rho;
    logic [17:0]        reg_ha;
    logic signed [18:0] reg_hl;
    logic [19:0]        reg_hh;
    logic [12:0]        reg_gas;

    t_rate_beat pending_rates[$];
    int         n_fail;
    longint     cycles;
    bit         rx_calm;
    int         hold_off;

    function automatic void shadow_reset();
        reg_tphi = 3072; reg_rho = 786432; reg_ha = 12; reg_hl = 12;
        reg_hh = 12; reg_tl = 3072; reg_th = 3072; reg_gas = 2035;
    endfunction

    function automatic longint unsigned exp_arg(longint h, longint unsigned t0,
                                                longint unsigned t, longint unsigned r);
        longint diff, mag;
        longint unsigned hm, dm, top, bot, rem, q;
        bit neg;
        diff = longint'(t) - longint'(t0);
        hm = h < 0 ? -h : h;
        dm = diff < 0 ? -diff : diff;
        neg = (h < 0) != (diff < 0);
        top = (hm * dm) << 18;
        bot = r * t0 * t;
        if (top >= 64 * bot) begin
            q = 64'd64 << 24;
        end else begin
            rem = top % bot;
            q = top / bot;
            for (int i = 0; i < 3; i++) begin
                rem = rem << 8;
                q = (q << 8) | (rem / bot);
                rem = rem % bot;
            end
        end
        mag = longint'(q);
        return neg ? -mag : mag;
    endfunction

    function automatic void exp_parts(longint x, output longint unsigned m, output int k);
        longint unsigned xm, ym, f, z, term, up;
        longint unsigned mask;
        mask = (64'd1 << 24) - 1;
        xm = x < 0 ? -x : x;
        ym = (xm * 64'd1549082005 + (64'd1 << 29)) >> 30;
        if (x >= 0) begin
            k = int'(ym >> 24);
            f = ym & mask;
        end else begin
            up = (ym + mask) >> 24;
            k = -int'(up);
            f = (up << 24) - ym;
        end
        z = (f * 64'd744261118 + (64'd1 << 23)) >> 24;
        term = 64'd1 << 30;
        m = term;
        for (int n = 1; n <= 11; n++) begin
            term = ((term * z) >> 30) / n;
            m += term;
        end
    endfunction

    function automatic longint unsigned scaled_quot(longint unsigned q, int e,
            longint unsigned d, longint unsigned maxv, ref bit ovf);
        longint unsigned a, r, r2;
        if (e <= 0) begin
            a = (-e) >= 64 ? 0 : (q >> (-e)) / d;
            if (a > maxv) begin
                ovf = 1; return maxv;
            end
            return a;
        end
        a = q / d;
        r = q % d;
        if (a > maxv) begin
            ovf = 1; return maxv;
        end
        for (int i = 0; i < e; i++) begin
            r2 = r << 1;
            a = a << 1;
            if (r2 >= d) begin
                r2 -= d; a |= 1;
            end
            r = r2;
            if (a > maxv) begin
                ovf = 1; return maxv;
            end
        end
        return a;
    endfunction

    function automatic t_rate_beat predict_rate(logic signed [15:0] temp);
        t_rate_beat res;
        longint unsigned t, tphi, tl, th, r, m, num, den, term, rate;
        int k;
        bit ovf;
        ovf = 0;
        t = longint'(temp) + 69926;
        tphi = reg_tphi == 0 ? 1 : reg_tphi;
        tl = reg_tl == 0 ? 1 : reg_tl;
        th = reg_th == 0 ? 1 : reg_th;
        r = reg_gas == 0 ? 1 : reg_gas;
        exp_parts(exp_arg(longint'(reg_ha), tphi, t, r), m, k);
        num = scaled_quot(longint'(reg_rho) * t * ((m + 512) >> 10), k - 36 + FB,
                          tphi, M48, ovf);
        den = 64'd1 << FB;
        exp_parts(exp_arg(longint'(reg_hl), tl, t, r), m, k);
        term = scaled_quot(m, k - 30 + FB, 1, M48, ovf);
        if (term > M48 - den) begin
            den = M48; ovf = 1;
        end else den += term;
        exp_parts(exp_arg(longint'(reg_hh), th, t, r), m, k);
        term = scaled_quot(m, k - 30 + FB, 1, M48, ovf);
        if (term > M48 - den) begin
            den = M48; ovf = 1;
        end else den += term;
        rate = scaled_quot(num, FB, den, M32, ovf);
        res.num = num[47:0];
        res.den = den[47:0];
        res.rate = rate[31:0];
        res.ovf = ovf;
        return res;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_OPT_TEMP: reg_tphi = value[16:0];
            REG_RHO:      reg_rho = value[23:0];
            REG_HA:       reg_ha = value[17:0];
            REG_HL:       reg_hl = value[18:0];
            REG_HH:       reg_hh = value[19:0];
            REG_TL:       reg_tl = value[16:0];
            REG_TH:       reg_th = value[16:0];
            REG_GAS:      reg_gas = value[12:0];
        endcase
    endtask

    // wait for the pipeline to drain, then let it settle
    task automatic drain();
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // offer one beat; hold until taken
    task automatic send_temp(logic signed [15:0] temp, bit typed, t_rate_beat res,
                             bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_temp_celsius <= temp;
        do @(posedge i_clk); while (o_stall);
        pending_rates.push_back(typed ? res : predict_rate(temp));
    endtask

    task automatic random_phase(int n, bit gaps);
        logic signed [15:0] temp;
        t_rate_beat dummy;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: temp = 16'($urandom);
                default: temp = $signed(16'($urandom_range(0, 14080))) - 16'sd2560;
            endcase
            send_temp(temp, 0, dummy, gaps);
        end
        i_valid <= 1'b0;
    endtask

    task automatic random_regs(bit extreme);
        apb_write(REG_OPT_TEMP, extreme ? ($urandom_range(0, 1) ? 0 : 131071)
                                        : $urandom_range(72000, 80000));
        apb_write(REG_RHO, extreme ? ($urandom_range(0, 1) ? 0 : 24'hFFFFFF) : $urandom);
        apb_write(REG_HA, extreme ? 18'h3FFFF : $urandom_range(0, 30000));
        apb_write(REG_HL, extreme ? ($urandom_range(0, 1) ? 32'h40000 : 32'h3FFFF)
                                  : $urandom);
        apb_write(REG_HH, extreme ? 20'hFFFFF : $urandom_range(0, 90000));
        apb_write(REG_TL, extreme ? 0 : $urandom_range(68000, 76000));
        apb_write(REG_TH, extreme ? 131071 : $urandom_range(74000, 82000));
        apb_write(REG_GAS, extreme ? ($urandom_range(0, 1) ? 0 : 8191) : $urandom);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_stall <= 1'b1;
            end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15) - 1) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rate_beat exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rates.size() == 0) begin
                $error("unexpected result beat");
                n_fail++;
            end else begin
                exp_r = pending_rates.pop_front();
                if (o_rate_numerator !== exp_r.num) begin
                    $error("rate_numerator exp %0d got %0d", exp_r.num, o_rate_numerator);
                    n_fail++;
                end
                if (o_rate_denominator !== exp_r.den) begin
                    $error("rate_denominator exp %0d got %0d", exp_r.den,
                           o_rate_denominator);
                    n_fail++;
                end
                if (o_development_rate !== exp_r.rate) begin
                    $error("development_rate exp %0d got %0d", exp_r.rate,
                           o_development_rate);
                    n_fail++;
                end
                if (o_overflow !== exp_r.ovf) begin
                    $error("overflow exp %0d got %0d", exp_r.ovf, o_overflow);
                    n_fail++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    t_stim_row directed[$];

    function automatic t_stim_row row(logic signed [15:0] temp, bit typed = 0,
                                      t_rate_beat res = '{0, 0, 0, 0});
        t_stim_row s;
        s.temp = temp; s.typed = typed; s.res = res;
        return s;
    endfunction

    initial begin
        n_fail = 0;
        cycles = 0;
        rx_calm = 0;
        hold_off = 0;
        shadow_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // put Tphi, TL and TH at 0 C so that every exponential is exactly 1 for a 0 C sample
        apb_write(REG_OPT_TEMP, 32'd69926);
        apb_write(REG_TL, 32'd69926);
        apb_write(REG_TH, 32'd69926);

        // at exactly Tphi, TL and TH with rho=12: each exp is 1
        directed.push_back(row(16'sd0, 1, '{48'd786432, 48'd196608, 32'd262144, 1'b0}));
        directed.push_back(row(16'sh7FFF));
        directed.push_back(row(-16'sh8000));
        directed.push_back(row(16'sd0));
        directed.push_back(row(16'sd6400));
        directed.push_back(row(-16'sd1));
        directed.push_back(row(16'sd1));
        directed.push_back(row(16'sh5555));
        directed.push_back(row(-16'sh2AAB));
        foreach (directed[i])
            send_temp(directed[i].temp, directed[i].typed, directed[i].res, 0);
        i_valid <= 1'b0;
        drain();

        // extreme register settings: huge exponents and zero registers
        for (int ph = 0; ph < 3; ph++) begin
            random_regs(1);
            foreach (directed[i]) send_temp(directed[i].temp, 0, directed[i].res, 1);
            random_phase(20, 1);
            drain();
        end

        // long receiver hold-off while the sender keeps offering
        random_regs(0);
        hold_off = 400;
        random_phase(250, 0);
        drain();

        shadow_reset();
        for (int r = 0; r < 8; r++) apb_write(t_reg_idx'(r), r == 0 ? 3072 :
            r == 1 ? 786432 : r == 7 ? 2035 : r == 5 || r == 6 ? 3072 : 12);
        random_phase(120, 1);
        drain();

        random_regs(0);
        random_phase(120, 1);
        drain();

        // quiet tail: no stalls, no gaps
        random_regs(0);
        rx_calm = 1;
        random_phase(100, 0);
        drain();

        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/ssi_pkg.sv
hdl/ssi_div.sv
hdl/ssi_exp.sv
hdl/ssi_development_rate_top.sv
verif/testbench.sv
